FILE: src/lcam_pkg.sv
`timescale 1ns / 1ps

package lcam_pkg;

  // Window and field sizes
  localparam int WINDOW    = 5;
  localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SAMPLE_W  = 24;
  localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW + 1);
  localparam int STREAK_W  = 32;
  localparam int PERIOD_W  = 8;

  // Shared divider: dividend width and step counter
  localparam int DIV_W     = 32;
  localparam int STEP_W    = $clog2(DIV_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(5);

endpackage

FILE: src/lcam_poll_if.sv
`timescale 1ns / 1ps

interface lcam_poll_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   sample_ok;
  logic signed [lcam_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, sample_ok, sample, input ready);
  modport sink   (input valid, sample_ok, sample, output ready);
endinterface

FILE: src/lcam_result_if.sv
`timescale 1ns / 1ps

interface lcam_result_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   average_valid;
  logic signed [lcam_pkg::SAMPLE_W-1:0]   average;
  logic        [lcam_pkg::STREAK_W-1:0]   miss_streak;
  logic                                   timeout_event;

  modport source (output valid, average_valid, average, miss_streak, timeout_event,
                  input ready);
  modport sink   (input valid, average_valid, average, miss_streak, timeout_event,
                  output ready);
endinterface

FILE: src/load_cell_average_and_miss_streak.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Payload
// poll     in   valid/ready    sample_ok, sample[23:0]
// result   out  valid/ready    average_valid, average[23:0], miss_streak[31:0],
//                              timeout_event
// cfg      in   cfg_write_en   cfg_write_data[7:0] (miss_event_period)
//
// One request at a time. A good poll passes through accept, sum, prep, divide
// and finish: the window is summed one entry a cycle, then a 32-step restoring
// divider forms the mean. A missed poll goes straight to the same divider,
// which yields streak mod period, and then to finish.
// rst clears ring pointers, fill count, streak, period (to 5) and handshakes.
// A finished result sits in the output register; the next poll is accepted
// while it waits, and the final step stalls only if it is still untaken.

module load_cell_average_and_miss_streak (
  input  logic                             clk,
  input  logic                             rst,
  lcam_poll_if.sink                        poll,
  lcam_result_if.source                    result,
  input  logic                             cfg_write_en,
  input  logic [lcam_pkg::PERIOD_W-1:0]    cfg_write_data
);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]                              state;

  // Block state
  logic signed [lcam_pkg::SAMPLE_W-1:0]    window_store [lcam_pkg::WINDOW];
  logic [lcam_pkg::IDX_W-1:0]              write_slot;
  logic [lcam_pkg::CNT_W-1:0]              filled_count;
  logic [lcam_pkg::STREAK_W-1:0]           missed_polls;
  logic [lcam_pkg::PERIOD_W-1:0]           miss_event_period;

  // Working registers
  logic                                    good_poll;
  logic [lcam_pkg::CNT_W-1:0]              sum_idx;
  logic signed [lcam_pkg::SUM_W-1:0]       acc;
  logic                                    neg;
  logic [lcam_pkg::DIV_W-1:0]              quo;
  logic [lcam_pkg::PERIOD_W-1:0]           rem;
  logic [lcam_pkg::PERIOD_W-1:0]           divisor;
  logic [lcam_pkg::STEP_W-1:0]             step;

  logic                                    accept;
  logic                                    out_free;
  logic                                    sum_last;
  logic [lcam_pkg::SUM_W-1:0]              acc_mag;
  logic [lcam_pkg::PERIOD_W:0]             shifted;
  logic [lcam_pkg::PERIOD_W:0]             diff;
  logic                                    fits;
  logic [lcam_pkg::SAMPLE_W-1:0]           quo_low;
  logic signed [lcam_pkg::SAMPLE_W-1:0]    avg;
  logic                                    ev;

  assign poll.ready = (state == ST_IDLE);
  assign accept     = poll.valid && poll.ready;
  assign out_free   = !result.valid || result.ready;
  assign sum_last   = (sum_idx == filled_count - lcam_pkg::CNT_W'(1));

  // Magnitude of the window sum for the unsigned divider
  assign acc_mag = acc[lcam_pkg::SUM_W-1] ? lcam_pkg::SUM_W'(-acc) : lcam_pkg::SUM_W'(acc);

  // Shared restoring divide step: one quotient bit per cycle
  assign shifted = {rem, quo[lcam_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});

  // Result forming
  assign quo_low = quo[lcam_pkg::SAMPLE_W-1:0];
  assign avg     = neg ? -quo_low : quo_low;
  assign ev      = (miss_event_period != '0) && (missed_polls != '0) && (rem == '0);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_event_period <= lcam_pkg::PERIOD_RESET;
    end else if (cfg_write_en) begin
      miss_event_period <= cfg_write_data;
    end
  end

  // Ring store, no reset: only written entries are ever summed
  always_ff @(posedge clk) begin
    if (accept && poll.sample_ok) begin
      window_store[write_slot] <= poll.sample;
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_slot   <= '0;
      filled_count <= '0;
      missed_polls <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && !(state == ST_FIN && out_free)) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (poll.sample_ok) begin
              missed_polls <= '0;
              write_slot   <= (write_slot == lcam_pkg::IDX_W'(lcam_pkg::WINDOW - 1))
                              ? '0 : write_slot + lcam_pkg::IDX_W'(1);
              if (filled_count != lcam_pkg::CNT_W'(lcam_pkg::WINDOW)) begin
                filled_count <= filled_count + lcam_pkg::CNT_W'(1);
              end
              state <= ST_SUM;
            end else begin
              missed_polls <= missed_polls + lcam_pkg::STREAK_W'(1);
              state        <= ST_DIV;
            end
          end
        end
        ST_SUM: begin
          if (sum_last) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == lcam_pkg::STEP_W'(lcam_pkg::DIV_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            result.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          good_poll <= poll.sample_ok;
          sum_idx   <= '0;
          acc       <= '0;
          rem       <= '0;
          step      <= '0;
          // a miss divides the new streak by the period
          quo       <= missed_polls + lcam_pkg::STREAK_W'(1);
          divisor   <= miss_event_period;
        end
      end
      ST_SUM: begin
        acc     <= acc + lcam_pkg::SUM_W'(window_store[sum_idx[lcam_pkg::IDX_W-1:0]]);
        sum_idx <= sum_idx + lcam_pkg::CNT_W'(1);
      end
      ST_PREP: begin
        neg     <= acc[lcam_pkg::SUM_W-1];
        quo     <= lcam_pkg::DIV_W'(acc_mag);
        divisor <= lcam_pkg::PERIOD_W'(filled_count);
        rem     <= '0;
        step    <= '0;
      end
      ST_DIV: begin
        rem  <= fits ? diff[lcam_pkg::PERIOD_W-1:0] : shifted[lcam_pkg::PERIOD_W-1:0];
        quo  <= {quo[lcam_pkg::DIV_W-2:0], fits};
        step <= step + lcam_pkg::STEP_W'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          result.average_valid <= good_poll;
          result.average       <= good_poll ? avg : '0;
          result.miss_streak   <= good_poll ? '0 : missed_polls;
          result.timeout_event <= good_poll ? 1'b0 : ev;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
